// ===== rtl/core/ifm_pkg.sv =====
// Shared types, codes and helper functions of the image frame mirror.
package ifm_pkg;

  localparam int unsigned PIX_W       = 64;
  localparam int unsigned BYTES_W     = 4;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned FMT_W       = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned DEF_MAX_WIDTH   = 64;
  localparam int unsigned DEF_MAX_HEIGHT  = 64;
  localparam int unsigned DEF_STORE_DEPTH = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ROWS    = 3'd4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [FMT_W-1:0] FMT_GRAY1  = 5'h00;
  localparam logic [FMT_W-1:0] FMT_RGB1   = 5'h02;
  localparam logic [FMT_W-1:0] FMT_RGBA1  = 5'h03;
  localparam logic [FMT_W-1:0] FMT_GRAY8  = 5'h0c;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 5'h0e;
  localparam logic [FMT_W-1:0] FMT_RGBA8  = 5'h0f;
  localparam logic [FMT_W-1:0] FMT_GRAY16 = 5'h10;
  localparam logic [FMT_W-1:0] FMT_RGB16  = 5'h12;
  localparam logic [FMT_W-1:0] FMT_RGBA16 = 5'h13;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_BAD_FORMAT     = 2'd1,
    ST_COUNT_MISMATCH = 2'd2,
    ST_NOT_LOADED     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RS_IDLE   = 2'd0,
    RS_SETTLE = 2'd1,
    RS_DIVIDE = 2'd2
  } rs_state_e;

  typedef struct packed {
    op_e                op;
    logic [BYTES_W-1:0] bytes;
    logic               done;
    status_e            status;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [BYTES_W-1:0] bytes;
    logic               done;
    status_e            status;
  } result_t;

  function automatic logic [BYTES_W-1:0] format_bytes(input logic [FMT_W-1:0] fmt);
    logic [BYTES_W-1:0] b;
    case (fmt)
      FMT_GRAY1:  b = 4'd1;
      FMT_RGB1:   b = 4'd3;
      FMT_RGBA1:  b = 4'd4;
      FMT_GRAY8:  b = 4'd1;
      FMT_RGB8:   b = 4'd3;
      FMT_RGBA8:  b = 4'd4;
      FMT_GRAY16: b = 4'd2;
      FMT_RGB16:  b = 4'd6;
      FMT_RGBA16: b = 4'd8;
      default:    b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [PIX_W-1:0] byte_mask(input logic [BYTES_W-1:0] bytes);
    logic [PIX_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIX_W / 8; i++) begin
      if (32'(bytes) > i) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/image_frame_mirror.sv =====
// Image frame mirror: an accepted input beat passes the descriptor queue, the
// store read stage and the result queue before its result is at the queue head;
// throughput one beat per cycle while the input is not full, set by the single
// store port. After any configuration write the input reports full while the
// fetch position is re-divided by the new width. Reset clears counters, queues
// and registers; the frame store keeps its contents and is undefined until written.
module image_frame_mirror #(
  parameter int unsigned MAX_WIDTH   = ifm_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = ifm_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned STORE_DEPTH = ifm_pkg::DEF_STORE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ifm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [ifm_pkg::PIX_W-1:0]       pixel_in_i,
  input  logic                            input_last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ifm_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [ifm_pkg::BYTES_W-1:0]     pixel_bytes_o,
  output logic                            frame_done_o,
  output logic [1:0]                      status_o
);

  import ifm_pkg::*;

  localparam int unsigned AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned DESC_W = $bits(meta_t) + AW + PIX_W;

  logic              fe_push;
  meta_t             fe_meta;
  logic [AW-1:0]     fe_addr;
  logic [PIX_W-1:0]  fe_data;
  logic              dq_full, dq_empty, dq_pop;
  logic [DESC_W-1:0] dq_rdata;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] dq_count;
  result_t           result;

  ifm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .pixel_in_i  (pixel_in_i),
    .input_last_i(input_last_i),
    .desc_full_i (dq_full),
    .desc_push_o (fe_push),
    .desc_meta_o (fe_meta),
    .desc_addr_o (fe_addr),
    .desc_data_o (fe_data)
  );

  ifm_fifo #(
    .WIDTH(DESC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_desc_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .wdata_i({fe_meta, fe_addr, fe_data}),
    .pop_i  (dq_pop),
    .rdata_o(dq_rdata),
    .full_o (dq_full),
    .empty_o(dq_empty),
    .count_o(dq_count)
  );

  ifm_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(!dq_empty && (dq_count != '0)),
    .desc_meta_i (meta_t'(dq_rdata[DESC_W-1 -: $bits(meta_t)])),
    .desc_addr_i (dq_rdata[PIX_W +: AW]),
    .desc_data_i (dq_rdata[PIX_W-1:0]),
    .desc_pop_o  (dq_pop),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result)
  );

  assign pixel_out_o   = result.pixel;
  assign pixel_bytes_o = result.bytes;
  assign frame_done_o  = result.done;
  assign status_o      = result.status;

endmodule

// ===== rtl/core/ifm_ram.sv =====
// Generic single-port RAM with registered read data.
module ifm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ifm_fifo.sv =====
// Small register-based FIFO used for the descriptor queue and the result queue.
module ifm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/ifm_front.sv =====
// Front end: configuration, frame bookkeeping and mirrored address generation.
module ifm_front #(
  parameter int unsigned MAX_WIDTH   = ifm_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = ifm_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned STORE_DEPTH = ifm_pkg::DEF_STORE_DEPTH,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ifm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic                              command_i,
  input  logic [ifm_pkg::PIX_W-1:0]         pixel_in_i,
  input  logic                              input_last_i,
  input  logic                              desc_full_i,
  output logic                              desc_push_o,
  output ifm_pkg::meta_t                    desc_meta_o,
  output logic [AW-1:0]                     desc_addr_o,
  output logic [ifm_pkg::PIX_W-1:0]         desc_data_o
);

  import ifm_pkg::*;

  localparam int unsigned CW    = $clog2(STORE_DEPTH + 2);
  localparam int unsigned CNT_W = $clog2(CW + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > max_v) begin
      r = DIM_W'(max_v);
    end
    return r;
  endfunction

  logic [DIM_W-1:0]   width_cfg_q, height_cfg_q;
  logic [FMT_W-1:0]   format_q;
  logic               mirror_cols_q, mirror_rows_q;
  logic [DIM_W-1:0]   w_eff_q, h_eff_q;
  logic [CW-1:0]      total_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [2*DIM_W-1:0] area;
  logic [CW-1:0]      total_d;

  logic [CW-1:0]      loaded_q, loaded_d, fetched_q, fetched_d;
  logic               ready_q, ready_d;
  logic [DIM_W-1:0]   row_q, row_d, col_q, col_d;

  rs_state_e          rs_state_q, rs_state_d;
  logic               busy, div_step;
  logic [CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [DIM_W-1:0]   div_rem_q, div_rem_d;
  logic [CW-1:0]      div_quo_q, div_quo_d;
  logic [DIM_W:0]     trial;

  logic               accept;
  logic [CW-1:0]      loaded_inc, fetched_inc;
  logic [DIM_W-1:0]   col_m, row_m;
  logic [2*DIM_W-1:0] fetch_addr;
  logic               addr_in_range;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q   <= DIM_W'(1);
      height_cfg_q  <= DIM_W'(1);
      format_q      <= FMT_GRAY1;
      mirror_cols_q <= 1'b0;
      mirror_rows_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:    width_cfg_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:   height_cfg_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_PIXEL_FORMAT:   format_q      <= cfg_wdata_i[FMT_W-1:0];
        REG_MIRROR_COLUMNS: mirror_cols_q <= cfg_wdata_i[0];
        REG_MIRROR_ROWS:    mirror_rows_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Derived frame geometry, registered from the configuration registers.
  assign area    = w_eff_q * h_eff_q;
  assign total_d = (32'(area) > STORE_DEPTH) ? CW'(STORE_DEPTH) : CW'(area);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q <= DIM_W'(1);
      h_eff_q <= DIM_W'(1);
      total_q <= CW'(1);
      bytes_q <= format_bytes(FMT_GRAY1);
    end else begin
      w_eff_q <= clamp_dim(width_cfg_q, MAX_WIDTH);
      h_eff_q <= clamp_dim(height_cfg_q, MAX_HEIGHT);
      total_q <= total_d;
      bytes_q <= format_bytes(format_q);
    end
  end

  // After a configuration write the fetch position is split again into row and
  // column for the new width, by a restoring divider one quotient bit a cycle.
  always_comb begin
    rs_state_d = rs_state_q;
    if (cfg_we_i) begin
      rs_state_d = RS_SETTLE;
    end else begin
      case (rs_state_q)
        RS_IDLE:   rs_state_d = RS_IDLE;
        RS_SETTLE: rs_state_d = RS_DIVIDE;
        RS_DIVIDE: rs_state_d = (div_cnt_q == CNT_W'(1)) ? RS_IDLE : RS_DIVIDE;
        default:   rs_state_d = RS_IDLE;
      endcase
    end
  end

  always_comb begin
    busy     = 1'b1;
    div_step = 1'b0;
    case (rs_state_q)
      RS_IDLE:   busy = 1'b0;
      RS_SETTLE: busy = 1'b1;
      RS_DIVIDE: div_step = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign trial = {div_rem_q, div_quo_q[CW-1]};

  always_comb begin
    div_cnt_d = div_cnt_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    if (rs_state_q == RS_SETTLE) begin
      div_cnt_d = CNT_W'(CW);
      div_rem_d = '0;
      div_quo_d = fetched_q;
    end else if (div_step) begin
      div_cnt_d = div_cnt_q - 1'b1;
      if (trial >= {1'b0, w_eff_q}) begin
        div_rem_d = DIM_W'(trial - {1'b0, w_eff_q});
        div_quo_d = {div_quo_q[CW-2:0], 1'b1};
      end else begin
        div_rem_d = trial[DIM_W-1:0];
        div_quo_d = {div_quo_q[CW-2:0], 1'b0};
      end
    end
  end

  assign full   = desc_full_i || busy;
  assign accept = push && !full;

  assign loaded_inc  = loaded_q + 1'b1;
  assign fetched_inc = fetched_q + 1'b1;

  assign col_m = mirror_cols_q ? (w_eff_q - DIM_W'(1) - col_q) : col_q;
  assign row_m = mirror_rows_q ? (h_eff_q - DIM_W'(1) - row_q) : row_q;
  assign fetch_addr    = (row_m * w_eff_q) + (2*DIM_W)'(col_m);
  assign addr_in_range = (32'(fetch_addr) < STORE_DEPTH);

  always_comb begin
    loaded_d  = loaded_q;
    fetched_d = fetched_q;
    ready_d   = ready_q;
    row_d     = row_q;
    col_d     = col_q;

    desc_meta_o.op     = OP_NONE;
    desc_meta_o.bytes  = bytes_q;
    desc_meta_o.done   = 1'b0;
    desc_meta_o.status = ST_OK;
    desc_addr_o        = '0;
    desc_data_o        = pixel_in_i & byte_mask(bytes_q);

    if (div_step && (div_cnt_q == CNT_W'(1))) begin
      row_d = DIM_W'(div_quo_d);
      col_d = div_rem_d;
    end

    if (accept) begin
      if (command_i == CMD_LOAD) begin
        ready_d = 1'b0;
        if (bytes_q == '0) begin
          desc_meta_o.status = ST_BAD_FORMAT;
          if (input_last_i) begin
            loaded_d = '0;
          end
        end else begin
          if (loaded_q < total_q) begin
            desc_meta_o.op = OP_WRITE;
            desc_addr_o    = AW'(loaded_q);
            loaded_d       = loaded_inc;
          end else begin
            loaded_d           = total_q + 1'b1;
            desc_meta_o.status = ST_COUNT_MISMATCH;
          end
          if (input_last_i) begin
            if (loaded_d == total_q) begin
              ready_d   = 1'b1;
              fetched_d = '0;
              row_d     = '0;
              col_d     = '0;
            end else begin
              desc_meta_o.status = ST_COUNT_MISMATCH;
            end
            loaded_d = '0;
          end
        end
      end else begin
        if (!ready_q) begin
          desc_meta_o.status = ST_NOT_LOADED;
        end else if (bytes_q == '0) begin
          desc_meta_o.status = ST_BAD_FORMAT;
        end else if (fetched_q >= total_q) begin
          desc_meta_o.status = ST_NOT_LOADED;
          ready_d   = 1'b0;
          fetched_d = '0;
          row_d     = '0;
          col_d     = '0;
        end else begin
          // Addresses beyond the store read as zero, so no access is issued.
          desc_meta_o.op = addr_in_range ? OP_READ : OP_NONE;
          desc_addr_o    = AW'(fetch_addr);
          fetched_d      = fetched_inc;
          if (col_q == w_eff_q - DIM_W'(1)) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          if (fetched_inc == total_q) begin
            desc_meta_o.done = 1'b1;
            ready_d   = 1'b0;
            fetched_d = '0;
            row_d     = '0;
            col_d     = '0;
          end
        end
      end
    end
  end

  assign desc_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      fetched_q  <= '0;
      ready_q    <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      rs_state_q <= RS_IDLE;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      div_quo_q  <= '0;
    end else begin
      loaded_q   <= loaded_d;
      fetched_q  <= fetched_d;
      ready_q    <= ready_d;
      row_q      <= row_d;
      col_q      <= col_d;
      rs_state_q <= rs_state_d;
      div_cnt_q  <= div_cnt_d;
      div_rem_q  <= div_rem_d;
      div_quo_q  <= div_quo_d;
    end
  end

endmodule

// ===== rtl/core/ifm_back.sv =====
// Back end: executes store writes and reads in order and queues the results.
module ifm_back #(
  parameter int unsigned STORE_DEPTH = ifm_pkg::DEF_STORE_DEPTH,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      desc_valid_i,
  input  ifm_pkg::meta_t            desc_meta_i,
  input  logic [AW-1:0]             desc_addr_i,
  input  logic [ifm_pkg::PIX_W-1:0] desc_data_i,
  output logic                      desc_pop_o,
  input  logic                      pop,
  output logic                      empty,
  output ifm_pkg::result_t          result_o
);

  import ifm_pkg::*;

  localparam int unsigned RES_CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                 issue;
  logic                 s1_valid_q;
  meta_t                s1_meta_q;
  logic [PIX_W-1:0]     ram_rdata;
  result_t              res_in;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_full;
  logic [$bits(result_t)-1:0] res_rdata;

  // A beat is issued only when the result queue has room for it and for the
  // one still in the read stage.
  assign issue = desc_valid_i &&
                 ((32'(res_count) + 32'(s1_valid_q)) < QUEUE_DEPTH);
  assign desc_pop_o = issue;

  ifm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (issue && (desc_meta_i.op == OP_WRITE)),
    .re_i   (issue && (desc_meta_i.op == OP_READ)),
    .addr_i (desc_addr_i),
    .wdata_i(desc_data_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_meta_q <= desc_meta_i;
    end
  end

  assign res_in.pixel  = (s1_meta_q.op == OP_READ) ? ram_rdata : '0;
  assign res_in.bytes  = s1_meta_q.bytes;
  assign res_in.done   = s1_meta_q.done;
  assign res_in.status = s1_meta_q.status;

  ifm_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_valid_q),
    .wdata_i(res_in),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .full_o (res_full),
    .empty_o(empty),
    .count_o(res_count)
  );

  // The issue check keeps the queue from overflowing; full only gates pushes.
  assign result_o = res_full ? result_t'(res_rdata) : result_t'(res_rdata);

endmodule
